### rtl/core/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpQmark = CpWidth'(8'h3F);
  localparam logic [CpWidth-1:0] CpZero  = '0;

  // Count of leading '?' results one byte can raise: up to three; one final result may follow.
  typedef logic [1:0] qcount_t;

  // Results that one decoded byte raises, handed to the output sequencer.
  typedef struct packed {
    qcount_t            nq;   // leading '?' results
    logic               fin;  // one closing result follows the '?'s
    logic [CpWidth-1:0] cp;   // value of the closing result
  } burst_t;

endpackage

### rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder, one byte per beat.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | in_valid_i, in_ready_o, byte_in_i    | in
//  out     | out_valid_o, out_ready_i,            | out
//          | codepoint_o, last_o                  |
//
// One byte is accepted per cycle unless a held byte waits for the result
// register; results pass the input register, then the result register. A byte
// raising several results holds the result register until its last beat is
// taken, one beat each. The input register takes one more byte while a result
// waits. Reset clears the sequence state and both valid stages.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CpWidth-1:0] codepoint_o,
  output logic               last_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       burst_free;
  logic       advance;
  burst_t     burst;

  // hand the held byte on once the result register can take its burst
  assign advance    = in_valid_q && burst_free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  utf8sd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_q),
    .commit_i (advance),
    .burst_o  (burst)
  );

  utf8sd_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .burst_i     (burst),
    .free_o      (burst_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .codepoint_o (codepoint_o),
    .last_o      (last_o)
  );

endmodule

### rtl/core/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and single-pass decode of one byte into a burst of results.
// ----------------------------------------------------------------------------
module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       commit_i,
  output burst_t     burst_o
);

  logic [CpWidth-1:0] pv_q, pv_d;
  logic [1:0]         needed_q, needed_d;
  logic [1:0]         taken_q, taken_d;

  logic               cont;
  logic [CpWidth-1:0] pv_shift;

  assign cont     = (byte_i[7:6] == 2'b10);
  assign pv_shift = {pv_q[CpWidth-7:0], byte_i[5:0]};

  always_comb begin
    burst_o  = '{nq: '0, fin: 1'b0, cp: CpZero};
    pv_d     = pv_q;
    needed_d = needed_q;
    taken_d  = taken_q;
    if (needed_q != 2'd0 && cont) begin
      // extend the pending sequence
      if (needed_q == 2'd1) begin
        burst_o.fin = 1'b1;
        burst_o.cp  = pv_shift;
        pv_d        = '0;
        needed_d    = 2'd0;
        taken_d     = 2'd0;
      end else begin
        pv_d     = pv_shift;
        needed_d = needed_q - 2'd1;
        taken_d  = taken_q + 2'd1;
      end
    end else begin
      // flush an interrupted sequence, then decode as a lead
      if (needed_q != 2'd0) begin
        burst_o.nq = (taken_q == 2'd3) ? 2'd3 : taken_q + 2'd1;
      end
      pv_d     = '0;
      needed_d = 2'd0;
      taken_d  = 2'd0;
      if (!byte_i[7]) begin
        burst_o.fin = 1'b1;
        burst_o.cp  = CpWidth'(byte_i);
      end else if (byte_i[7:5] == 3'b110) begin
        pv_d     = CpWidth'(byte_i[4:0]);
        needed_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        pv_d     = CpWidth'(byte_i[3:0]);
        needed_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        pv_d     = CpWidth'(byte_i[2:0]);
        needed_d = 2'd3;
      end else begin
        burst_o.fin = 1'b1;
        burst_o.cp  = CpQmark;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q     <= '0;
      needed_q <= 2'd0;
      taken_q  <= 2'd0;
    end else if (commit_i) begin
      pv_q     <= pv_d;
      needed_q <= needed_d;
      taken_q  <= taken_d;
    end
  end

  // The continuation count is clear whenever no sequence is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (needed_q == 2'd0) |-> (taken_q == 2'd0))
    else $error("continuation count set with no sequence pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (needed_q != 2'd0) |-> (taken_q != 2'd3))
    else $error("continuation count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_i |=> $stable(needed_q) && $stable(taken_q))
    else $error("sequence state moved without a committed byte");

endmodule

### rtl/core/utf8sd_burst.sv
// ----------------------------------------------------------------------------
// utf8sd_burst
// Result register: plays out one burst of results, one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module utf8sd_burst
  import utf8sd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  burst_t             burst_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CpWidth-1:0] codepoint_o,
  output logic               last_o
);

  qcount_t            nq_q, nq_d;
  logic               fin_q, fin_d;
  logic [CpWidth-1:0] cp_q;
  logic               busy;
  logic               take;

  assign busy        = (nq_q != 2'd0) || fin_q;
  assign out_valid_o = busy;
  assign codepoint_o = (nq_q != 2'd0) ? CpQmark : cp_q;
  assign last_o      = (nq_q == 2'd0) || ((nq_q == 2'd1) && !fin_q);
  assign take        = busy && out_ready_i;
  assign free_o      = !busy || (out_ready_i && last_o);

  always_comb begin
    nq_d  = nq_q;
    fin_d = fin_q;
    if (load_i) begin
      nq_d  = burst_i.nq;
      fin_d = burst_i.fin;
    end else if (take) begin
      if (nq_q != 2'd0) begin
        nq_d = nq_q - 2'd1;
      end else begin
        fin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      nq_q  <= nq_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cp_q <= burst_i.cp;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("burst loaded over pending beats");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_o && !load_i) |=> !out_valid_o)
    else $error("beats left after the last one was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !out_ready_i) |=> busy && $stable(codepoint_o) && $stable(last_o))
    else $error("stalled beat changed");

endmodule

### verif/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the UTF-8 stream decoder. A scoreboard keeps its own
// decoder state, predicts the code point beats of every accepted byte and
// checks each output beat in order. Directed bytes cover ASCII, every lead
// length, the largest code point, stray and invalid bytes, interrupted
// sequences and end of string. Random text follows, mostly well-formed, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb
  import utf8sd_pkg::*;
();

  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned NumRandom     = 138;
  localparam int unsigned QuietTail     = 40;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               last;
  } cp_beat_t;

  class cp_scoreboard;
    logic [CpWidth-1:0] partial;
    logic [1:0]         need;
    logic [1:0]         taken;
    logic [CpWidth-1:0] burst[$];
    cp_beat_t           pending_q[$];
    int unsigned        n_err;

    function new();
      partial = '0;
      need    = '0;
      taken   = '0;
      n_err   = 0;
    endfunction

    function void go_idle();
      partial = '0;
      need    = '0;
      taken   = '0;
    endfunction

    // Decode b as a lead byte with no sequence pending.
    function void start_lead(logic [7:0] b);
      if (!b[7]) begin
        burst.push_back(CpWidth'(b));
        return;
      end
      taken = '0;
      if (b[7:5] == 3'b110) begin
        partial = CpWidth'(b[4:0]);
        need    = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial = CpWidth'(b[3:0]);
        need    = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial = CpWidth'(b[2:0]);
        need    = 2'd3;
      end else begin
        burst.push_back(CpQmark);
      end
    endfunction

    // Note an accepted input beat and queue the code points it raises.
    function void note_byte(logic [7:0] b);
      int i;
      burst.delete();
      if (need != 0) begin
        if (b[7:6] == 2'b10) begin
          partial = {partial[CpWidth-7:0], b[5:0]};
          taken   = taken + 2'd1;
          need    = need - 2'd1;
          if (need == 0) begin
            burst.push_back(partial);
            go_idle();
          end
        end else begin
          // one '?' for the lead, one per continuation already taken
          burst.push_back(CpQmark);
          for (i = 0; i < int'(taken) && burst.size() < 3; i++)
            burst.push_back(CpQmark);
          go_idle();
          start_lead(b);
        end
      end else begin
        start_lead(b);
      end
      for (i = 0; i < burst.size(); i++)
        pending_q.push_back('{cp: burst[i], last: (i == burst.size() - 1)});
    endfunction

    function void check_result(logic [CpWidth-1:0] cp, logic last);
      cp_beat_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat cp=%06h last=%0b", $time, cp, last);
        n_err++;
        return;
      end
      want = pending_q.pop_front();
      if (cp !== want.cp) begin
        $display("%0t: codepoint mismatch: expected %06h, actual %06h",
                 $time, want.cp, cp);
        n_err++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
        n_err++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         byte_in_i   = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CpWidth-1:0] codepoint_o;
  logic               last_o;

  cp_scoreboard sb = new();
  logic [7:0]   stim_q[$];
  bit           no_idle  = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  quiet_cnt = 0;

  utf8_stream_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .codepoint_o (codepoint_o),
    .last_o      (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(codepoint_o, last_o);
  end

  // Count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d beats outstanding", $time, sb.outstanding());
      $display("** utf8_stream_decoder: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int unsigned n;
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
  endtask

  // Queue one random sequence; a broken multi-byte one is cut short, and every
  // broken one is followed by an arbitrary byte.
  task automatic add_random_seq();
    logic [7:0]  seq[4];
    int unsigned len;
    int unsigned keep;
    bit          broken;
    len    = $urandom_range(1, 4);
    broken = ($urandom_range(0, 4) == 0);
    case (len)
      1: seq[0] = {1'b0, 7'($urandom_range(0, 127))};
      2: seq[0] = {3'b110, 5'($urandom_range(0, 31))};
      3: seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
      default: seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom_range(0, 63))};
    keep = (broken && len > 1) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < int'(keep); i++) stim_q.push_back(seq[i]);
    if (broken) stim_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned n_dir;
    int unsigned hold_at;
    int unsigned gap;

    // ASCII and end of string, complete 2/3/4-byte forms, the largest value
    stim_q = '{8'h00, 8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    // stray continuation, invalid leads
    stim_q.push_back(8'h80);
    stim_q.push_back(8'hF8);
    stim_q.push_back(8'hFF);
    // interruptions: by ASCII, by end of string after two continuations,
    // by a new lead, by an invalid lead
    stim_q.push_back(8'hE2); stim_q.push_back(8'h82); stim_q.push_back(8'h41);
    stim_q.push_back(8'hF4); stim_q.push_back(8'h90); stim_q.push_back(8'h80);
    stim_q.push_back(8'h00);
    stim_q.push_back(8'hC3); stim_q.push_back(8'hE2); stim_q.push_back(8'h82);
    stim_q.push_back(8'hAC);
    stim_q.push_back(8'hE2); stim_q.push_back(8'hFF);
    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + NumRandom) add_random_seq();
    hold_at = n_dir + (stim_q.size() - n_dir) / 3;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i + QuietTail >= stim_q.size()) no_idle = 1'b1;
      if (i == int'(hold_at)) hold_req = 1'b1;
      gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      send_byte(stim_q[i], gap);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.n_err == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule
